/* hdl/kmd_pkg.sv */
`timescale 1ns / 1ps

package kmd_pkg;

  // Storage and report sizing
  localparam int unsigned KEY_SLOTS        = 128;
  localparam int unsigned REPORT_KEYS      = 6;
  localparam int unsigned DEBOUNCE_SAMPLES = 8;

  localparam int unsigned KEY_AW  = $clog2(KEY_SLOTS);
  localparam int unsigned PTR_W   = $clog2(KEY_SLOTS + 1);
  localparam int unsigned SLOT_CW = $clog2(REPORT_KEYS + 1);
  localparam int unsigned HIST_W  = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned IDX_W   = 9;

  typedef logic [KEY_AW-1:0]  addr_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [SLOT_CW-1:0] slot_cnt_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [HIST_W-1:0]  hist_t;
  typedef logic [IDX_W-1:0]   idx_t;

  localparam hist_t HELD_MASK = hist_t'((1 << DEBOUNCE_SAMPLES) - 1);

  // Keycodes with special meaning
  localparam code_t CODE_LSHIFT = 8'd225;
  localparam code_t CODE_RSHIFT = 8'd229;
  localparam code_t CODE_MOD_LO = 8'd224;
  localparam code_t CODE_MOD_HI = 8'd231;

  // Reset values of the configuration registers
  localparam logic [3:0] ROWS_RST  = 4'd8;
  localparam logic [4:0] COLS_RST  = 5'd16;
  localparam code_t      FNKEY_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BASE   = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_FN     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_FNKEY = 2'd2
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic clear_wr;
    logic sample_wr;
    logic walk_start;
    logic walk_restart;
    logic walk_run;
    logic pass2;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic in_valid;
    logic in_sample;
    logic item_end;
    logic pass_done;
    logic out_free;
  } sts_t;

endpackage

/* hdl/kmd_if.sv */
`timescale 1ns / 1ps

// Key sample / layer write channel
interface kmd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] row;
  logic [3:0] col;
  logic       closed;
  logic       scan_end;
  logic [7:0] keycode;

  modport source (output valid, op, row, col, closed, scan_end, keycode, input ready);
  modport sink   (input valid, op, row, col, closed, scan_end, keycode, output ready);
endinterface

// HID report channel
interface kmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] slot0;
  logic [7:0] slot1;
  logic [7:0] slot2;
  logic [7:0] slot3;
  logic [7:0] slot4;
  logic [7:0] slot5;
  logic       fn_active;
  logic       shift_active;

  modport source (output valid, modifiers, slot0, slot1, slot2, slot3, slot4, slot5,
                  fn_active, shift_active, input ready);
  modport sink   (input valid, modifiers, slot0, slot1, slot2, slot3, slot4, slot5,
                  fn_active, shift_active, output ready);
endinterface

// Configuration register write channel
interface kmd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/kmd_ram.sv */
`timescale 1ns / 1ps

module kmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/kmd_ctrl.sv */
`timescale 1ns / 1ps

module kmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kmd_pkg::sts_t sts_i,
  output kmd_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SAMPLE = 6'b000100,
    ST_FLAGS  = 6'b001000,
    ST_MAP    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid && sts_i.in_sample) begin
          state_d = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        cmd_o.sample_wr = 1'b1;
        if (sts_i.item_end) begin
          cmd_o.walk_start = 1'b1;
          state_d          = ST_FLAGS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLAGS: begin
        cmd_o.walk_run = 1'b1;
        if (sts_i.pass_done) begin
          cmd_o.walk_restart = 1'b1;
          state_d            = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.walk_run = 1'b1;
        cmd_o.pass2    = 1'b1;
        if (sts_i.pass_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/kmd_dp.sv */
`timescale 1ns / 1ps

module kmd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  kmd_cfg_if.sink       cfg_i,
  kmd_in_if.sink        in_i,
  kmd_out_if.source     out_o,
  input  kmd_pkg::cmd_t cmd_i,
  output kmd_pkg::sts_t sts_o
);

  // Configuration registers
  logic [3:0]     rows_q;
  logic [4:0]     cols_q;
  kmd_pkg::code_t fnkey_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= kmd_pkg::ROWS_RST;
      cols_q  <= kmd_pkg::COLS_RST;
      fnkey_q <= kmd_pkg::FNKEY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kmd_pkg::CFG_ROWS:  rows_q  <= cfg_i.data[3:0];
        kmd_pkg::CFG_COLS:  cols_q  <= cfg_i.data[4:0];
        kmd_pkg::CFG_FNKEY: fnkey_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input key index and range check
  logic [7:0]      in_prod;
  kmd_pkg::idx_t   in_idx;
  kmd_pkg::addr_t  in_addr;
  logic            in_ok;
  logic            in_acc;
  logic            in_sample;
  logic            lay_we;

  assign in_prod   = 8'(in_i.row * cols_q);
  assign in_idx    = kmd_pkg::idx_t'(in_prod) + kmd_pkg::idx_t'(in_i.col);
  assign in_addr   = in_idx[kmd_pkg::KEY_AW-1:0];
  assign in_ok     = (4'(in_i.row) < rows_q) && (5'(in_i.col) < cols_q) &&
                     (in_idx < kmd_pkg::idx_t'(kmd_pkg::KEY_SLOTS));
  assign in_sample = (in_i.op == kmd_pkg::OP_SAMPLE);
  assign in_i.ready = cmd_i.in_ready;
  assign in_acc    = in_i.valid && cmd_i.in_ready;
  assign lay_we    = in_acc && in_ok && !in_sample;

  // Captured sample transaction
  kmd_pkg::addr_t item_addr_q;
  logic           item_ok_q;
  logic           item_closed_q;
  logic           item_end_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_addr_q   <= in_addr;
      item_ok_q     <= in_ok;
      item_closed_q <= in_i.closed;
      item_end_q    <= in_i.scan_end;
    end
  end

  // Walk pointer, shared with the clearing pass
  logic [8:0]      lim_prod;
  kmd_pkg::ptr_t   limit_d, limit_q;
  kmd_pkg::ptr_t   ptr_q;
  kmd_pkg::addr_t  walk_addr;
  logic            issue;
  logic            rd_vld_q;

  assign lim_prod  = 9'(rows_q * cols_q);
  assign limit_d   = (lim_prod > 9'(kmd_pkg::KEY_SLOTS)) ?
                     kmd_pkg::ptr_t'(kmd_pkg::KEY_SLOTS) : kmd_pkg::ptr_t'(lim_prod);
  assign walk_addr = ptr_q[kmd_pkg::KEY_AW-1:0];
  assign issue     = cmd_i.walk_run && (ptr_q < limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.walk_start || cmd_i.walk_restart) begin
        ptr_q    <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        if (cmd_i.clear_wr || issue) begin
          ptr_q <= ptr_q + kmd_pkg::ptr_t'(1);
        end
        rd_vld_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      limit_q <= limit_d;
    end
  end

  // Key state memories
  kmd_pkg::hist_t hist_rd, base_rd, shift_rd, fn_rd;
  kmd_pkg::hist_t hist_wdata;
  kmd_pkg::code_t lay_wdata;
  kmd_pkg::addr_t hist_waddr, hist_raddr, lay_waddr;
  logic           hist_we;

  assign hist_we    = cmd_i.clear_wr || (cmd_i.sample_wr && item_ok_q);
  assign hist_waddr = cmd_i.clear_wr ? walk_addr : item_addr_q;
  assign hist_wdata = cmd_i.clear_wr ? '0 : {hist_rd[kmd_pkg::HIST_W-2:0], item_closed_q};
  assign hist_raddr = cmd_i.in_ready ? in_addr : walk_addr;
  assign lay_waddr  = cmd_i.clear_wr ? walk_addr : in_addr;
  assign lay_wdata  = cmd_i.clear_wr ? '0 : in_i.keycode;

  kmd_ram #(.WIDTH(kmd_pkg::HIST_W), .DEPTH(kmd_pkg::KEY_SLOTS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  kmd_ram #(.WIDTH(kmd_pkg::CODE_W), .DEPTH(kmd_pkg::KEY_SLOTS)) u_base (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_wr || (lay_we && in_i.op == kmd_pkg::OP_BASE)),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .raddr_i (walk_addr),
    .rdata_o (base_rd)
  );

  kmd_ram #(.WIDTH(kmd_pkg::CODE_W), .DEPTH(kmd_pkg::KEY_SLOTS)) u_shift (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_wr || (lay_we && in_i.op == kmd_pkg::OP_SHIFT)),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .raddr_i (walk_addr),
    .rdata_o (shift_rd)
  );

  kmd_ram #(.WIDTH(kmd_pkg::CODE_W), .DEPTH(kmd_pkg::KEY_SLOTS)) u_fn (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_wr || (lay_we && in_i.op == kmd_pkg::OP_FN)),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .raddr_i (walk_addr),
    .rdata_o (fn_rd)
  );

  // Per-key decode of the walk data
  logic           held;
  logic           base_is_fn, base_is_shift;
  kmd_pkg::code_t code;
  logic           code_skip, code_mod;

  assign held          = (hist_rd & kmd_pkg::HELD_MASK) == kmd_pkg::HELD_MASK;
  assign base_is_fn    = (fnkey_q != '0) && (base_rd == fnkey_q);
  assign base_is_shift = (base_rd == kmd_pkg::CODE_LSHIFT) ||
                         (base_rd == kmd_pkg::CODE_RSHIFT);

  logic fn_q, sh_q;

  always_comb begin
    if (fn_q) begin
      code = fn_rd;
    end else if (sh_q) begin
      code = (shift_rd != '0) ? shift_rd : base_rd;
    end else begin
      code = base_rd;
    end
  end

  assign code_skip = (code == '0) || ((fnkey_q != '0) && (code == fnkey_q));
  assign code_mod  = (code >= kmd_pkg::CODE_MOD_LO) && (code <= kmd_pkg::CODE_MOD_HI);

  // Report accumulation
  logic [7:0]         mods_q;
  kmd_pkg::slot_cnt_t used_q;
  kmd_pkg::code_t     slots_q [kmd_pkg::REPORT_KEYS];
  logic               acc_vld;

  assign acc_vld = cmd_i.walk_run && rd_vld_q && held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q   <= 1'b0;
      sh_q   <= 1'b0;
      mods_q <= '0;
      used_q <= '0;
    end else if (cmd_i.walk_start) begin
      fn_q   <= 1'b0;
      sh_q   <= 1'b0;
      mods_q <= '0;
      used_q <= '0;
    end else if (acc_vld && !cmd_i.pass2) begin
      if (base_is_fn) begin
        fn_q <= 1'b1;
      end else if (base_is_shift) begin
        sh_q <= 1'b1;
      end
    end else if (acc_vld && !code_skip) begin
      if (code_mod) begin
        mods_q[code[2:0]] <= 1'b1;
      end else if (used_q < kmd_pkg::slot_cnt_t'(kmd_pkg::REPORT_KEYS)) begin
        used_q <= used_q + kmd_pkg::slot_cnt_t'(1);
      end
    end
  end

  // Slot fill at the current count
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < kmd_pkg::REPORT_KEYS; k++) begin
      if (cmd_i.walk_start) begin
        slots_q[k] <= '0;
      end else if (acc_vld && cmd_i.pass2 && !code_skip && !code_mod &&
                   used_q == kmd_pkg::slot_cnt_t'(k)) begin
        slots_q[k] <= code;
      end
    end
  end

  // Six report slots, unused ones read zero
  kmd_pkg::code_t slot_w [6];

  for (genvar g = 0; g < 6; g++) begin : g_slot
    if (g < kmd_pkg::REPORT_KEYS) begin : g_used
      assign slot_w[g] = slots_q[g];
    end else begin : g_zero
      assign slot_w[g] = '0;
    end
  end

  // Output register
  logic           out_vld_q;
  logic [7:0]     res_mods_q;
  kmd_pkg::code_t res_slot_q [6];
  logic           res_fn_q, res_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_mods_q <= mods_q;
      res_fn_q   <= fn_q;
      res_sh_q   <= sh_q;
      for (int k = 0; k < 6; k++) begin
        res_slot_q[k] <= slot_w[k];
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.modifiers    = res_mods_q;
  assign out_o.slot0        = res_slot_q[0];
  assign out_o.slot1        = res_slot_q[1];
  assign out_o.slot2        = res_slot_q[2];
  assign out_o.slot3        = res_slot_q[3];
  assign out_o.slot4        = res_slot_q[4];
  assign out_o.slot5        = res_slot_q[5];
  assign out_o.fn_active    = res_fn_q;
  assign out_o.shift_active = res_sh_q;

  // Status back to the controller
  assign sts_o.clear_done = (ptr_q == kmd_pkg::ptr_t'(kmd_pkg::KEY_SLOTS - 1));
  assign sts_o.in_valid   = in_i.valid;
  assign sts_o.in_sample  = in_sample;
  assign sts_o.item_end   = item_end_q;
  assign sts_o.pass_done  = !issue && !rd_vld_q;
  assign sts_o.out_free   = !out_vld_q || out_o.ready;

`ifndef SYNTHESIS
  // Slot count never runs past the report size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= kmd_pkg::slot_cnt_t'(kmd_pkg::REPORT_KEYS))
    else $error("slot count past report size");

  // A report is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_vld_q || out_o.ready))
    else $error("report overwritten before delivery");

  // Walk pointer stays inside the scanned range
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_run && !cmd_i.walk_restart |=> ptr_q <= limit_q)
    else $error("walk pointer past limit");

  // Walk read data only follows an issued address
  a_rd_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.walk_run))
    else $error("walk data without read");
`endif

endmodule

/* hdl/key_matrix_debounce_hid_report_core.sv */
`timescale 1ns / 1ps
// Layer write: taken while idle; the core stays idle. Key sample without scan end:
// history read, then write back through the history RAM port.
// Scan end: the history write back, then two walks over L keys, one key per cycle,
// L = min(rows * columns, 128); the report is then loaded once the output is free.
// Reset: registers take their reset values, then a clearing pass zeroes all 128
// key RAM slots; all input transactions are held off, configuration writes are taken.

module key_matrix_debounce_hid_report_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmd_cfg_if.sink   cfg_i,
  kmd_in_if.sink    in_i,
  kmd_out_if.source out_o
);

  kmd_pkg::cmd_t cmd;
  kmd_pkg::sts_t sts;

  kmd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  kmd_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
